### rtl/jbt_pkg.sv
`timescale 1ns / 1ps
// jbt_pkg: shared types and constants for the json byte tokenizer
package jbt_pkg;

  // token length counter width
  localparam int LEN_BITS = 16;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  // byte codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_LBRC   = 8'h7B;
  localparam logic [7:0] CH_RBRC   = 8'h7D;

  // token type codes as they appear on the output
  typedef enum logic [3:0] {
    TOK_WS    = 4'd0,
    TOK_NL    = 4'd1,
    TOK_LBRK  = 4'd2,
    TOK_RBRK  = 4'd3,
    TOK_LBRC  = 4'd4,
    TOK_RBRC  = 4'd5,
    TOK_COLON = 4'd6,
    TOK_COMMA = 4'd7,
    TOK_STR   = 4'd8,
    TOK_MULTI = 4'd9,
    TOK_VALUE = 4'd10,
    TOK_LCMT  = 4'd11,
    TOK_BCMT  = 4'd12,
    TOK_BAD   = 4'd13,
    TOK_EOF   = 4'd14
  } tok_t;

  // kind of token currently open
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_WS     = 4'd1,
    MODE_CR     = 4'd2,
    MODE_SLASH  = 4'd3,
    MODE_STR    = 4'd4,
    MODE_LCMT   = 4'd5,
    MODE_BCMT   = 4'd6,
    MODE_VAL    = 4'd7,
    MODE_BADVAL = 4'd8
  } mode_t;

  // lexer state carried from byte to byte
  typedef struct packed {
    mode_t               mode;
    logic                quote_single;
    logic                esc;
    logic [1:0]          flags;       // bit0 multiline, bit1 invalid
    logic                prev_star;
    logic                prev_cr;
    logic                slash_held;
    logic [LEN_BITS-1:0] count;
    logic                over;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    mode: MODE_IDLE, quote_single: 1'b0, esc: 1'b0, flags: 2'b00,
    prev_star: 1'b0, prev_cr: 1'b0, slash_held: 1'b0,
    count: '0, over: 1'b0
  };

  // one closed token
  typedef struct packed {
    tok_t                kind;
    logic [LEN_BITS-1:0] length;
    logic                over;
  } tok_res_t;

  // all results caused by one input byte
  typedef struct packed {
    tok_res_t first;
    tok_res_t second;
    logic     two;
  } tok_pair_t;

endpackage

### rtl/json_byte_tokenizer.sv
`timescale 1ns / 1ps
// json_byte_tokenizer: byte-serial JSON lexer with comment support
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------------
//   in      | in_valid, in_stall  | data_byte, end_of_input
//   out     | out_valid, out_stall| token_type, token_length, length_saturated, last
//
// One byte is taken per cycle while in_stall is low; its lexer update is a short
// combinational step into the state register, and its results go into a two-entry
// result queue. A byte that closes two tokens presents its results on the output one
// after the other, so such bytes slow the stream; else one per cycle unless stalled.
// Results appear on the output at the earliest the cycle after the byte is taken.
// in_stall rises only when the result queue holds two entries.
// Synchronous reset returns the lexer to idle and empties the queue.
module json_byte_tokenizer
  import jbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                end_of_input,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          token_type,
  output logic [LEN_BITS-1:0] token_length,
  output logic                length_saturated,
  output logic                last
);

  lex_state_t st;
  lex_state_t st_next;
  tok_pair_t  lex_pair;
  logic [1:0] lex_cnt;
  tok_pair_t  q0;
  tok_pair_t  q1;
  logic [1:0] q_cnt;
  logic       sel;
  logic       in_acc;
  logic       out_acc;
  logic       push;
  logic       pop;
  tok_res_t   head;

  jbt_lexer u_lexer (
    .st           (st),
    .data_byte    (data_byte),
    .end_of_input (end_of_input),
    .st_next      (st_next),
    .pair         (lex_pair),
    .res_cnt      (lex_cnt)
  );

  // handshake
  assign in_stall  = (q_cnt == 2'd2);
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = (q_cnt != 2'd0);
  assign out_acc   = out_valid & ~out_stall;
  assign push      = in_acc & (lex_cnt != 2'd0);
  assign pop       = out_acc & (~q0.two | sel);

  // lexer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= LEX_RESET;
    end else if (in_acc) begin
      st <= st_next;
    end
  end

  // result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
      sel   <= 1'b0;
    end else begin
      if (out_acc) begin
        sel <= ~pop;
      end
      if (push && !pop) begin
        q_cnt <= q_cnt + 2'd1;
      end else if (pop && !push) begin
        q_cnt <= q_cnt - 2'd1;
      end
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (push && pop) begin
      q0 <= lex_pair;
    end else if (pop) begin
      q0 <= q1;
    end else if (push) begin
      if (q_cnt == 2'd0) begin
        q0 <= lex_pair;
      end else begin
        q1 <= lex_pair;
      end
    end
  end

  // output selection from the head entry
  assign head             = sel ? q0.second : q0.first;
  assign token_type       = head.kind;
  assign token_length     = head.length;
  assign length_saturated = head.over;
  assign last             = q0.two ? sel : 1'b1;

  // queue never holds more than two entries
  a_qcnt_range: assert property (@(posedge clk) disable iff (rst)
    q_cnt != 2'd3)
    else $error("result queue count out of range");

  // second result is only selected for a valid two-result head
  a_sel_two: assert property (@(posedge clk) disable iff (rst)
    sel |-> (q0.two && out_valid))
    else $error("second result selected without a two-result head");

  // a taken non-final result is followed by the rest of its byte
  a_rest_follows: assert property (@(posedge clk) disable iff (rst)
    (out_acc && !last) |=> (out_valid && sel))
    else $error("second result lost after first was taken");

  // end of input always yields results and leaves the lexer idle
  a_eof_results: assert property (@(posedge clk) disable iff (rst)
    (in_acc && end_of_input) |-> (lex_cnt != 2'd0))
    else $error("end of input produced no result");

  a_eof_idle: assert property (@(posedge clk) disable iff (rst)
    (in_acc && end_of_input) |=> (st.mode == MODE_IDLE && st.count == '0))
    else $error("lexer not idle after end of input");

endmodule

### rtl/jbt_lexer.sv
`timescale 1ns / 1ps
// jbt_lexer: next-state and token-close logic for one input byte
module jbt_lexer
  import jbt_pkg::*;
(
  input  lex_state_t st,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  output lex_state_t st_next,
  output tok_pair_t  pair,
  output logic [1:0] res_cnt
);

  function automatic logic is_delim(input logic [7:0] c);
    return c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SPACE ||
           c == CH_DQUOTE || c == CH_COMMA || c == CH_COLON ||
           c == CH_LBRK || c == CH_RBRK || c == CH_LBRC || c == CH_RBRC;
  endfunction

  logic [LEN_BITS-1:0] inc_cnt;
  logic                inc_over;
  logic                p_valid;
  tok_res_t            p_res;
  logic                s_valid;
  tok_res_t            s_res;
  logic                do_open;
  logic [1:0]          sflags;
  logic [7:0]          quote_ch;
  logic                is_ctrl;
  tok_t                val_kind;

  // saturating length increment
  assign inc_cnt  = (st.count == LEN_MAX) ? st.count : st.count + LEN_BITS'(1);
  assign inc_over = st.over | (st.count == LEN_MAX);

  assign quote_ch = st.quote_single ? CH_SQUOTE : CH_DQUOTE;
  assign is_ctrl  = (data_byte != 8'h00) && (data_byte < CH_SPACE);
  assign val_kind = (st.mode == MODE_BADVAL) ? TOK_BAD : TOK_VALUE;

  // state update for the open token, then optional open of a new token
  always_comb begin
    st_next = st;
    p_valid = 1'b0;
    p_res   = '{kind: TOK_WS, length: st.count, over: st.over};
    s_valid = 1'b0;
    s_res   = '{kind: TOK_WS, length: LEN_BITS'(1), over: 1'b0};
    do_open = 1'b0;
    sflags  = st.flags;

    if (end_of_input) begin
      // flush pending token, then end-of-file
      if (st.mode != MODE_IDLE) begin
        p_valid = 1'b1;
        unique case (st.mode)
          MODE_WS:   p_res.kind = TOK_WS;
          MODE_CR:   p_res.kind = TOK_NL;
          MODE_LCMT: p_res.kind = TOK_LCMT;
          MODE_VAL:  p_res.kind = TOK_VALUE;
          default:   p_res.kind = TOK_BAD;
        endcase
      end
      s_valid = 1'b1;
      s_res   = '{kind: TOK_EOF, length: '0, over: 1'b0};
      st_next = LEX_RESET;
    end else begin
      unique case (st.mode)
        MODE_WS: begin
          if (data_byte == CH_SPACE || data_byte == CH_TAB) begin
            st_next.count = inc_cnt;
            st_next.over  = inc_over;
          end else begin
            p_valid    = 1'b1;
            p_res.kind = TOK_WS;
            do_open    = 1'b1;
          end
        end
        MODE_CR: begin
          st_next.prev_cr = 1'b0;
          p_valid    = 1'b1;
          p_res.kind = TOK_NL;
          if (data_byte == CH_LF) begin
            p_res.length  = inc_cnt;
            p_res.over    = inc_over;
            st_next.count = inc_cnt;
            st_next.over  = inc_over;
            st_next.mode  = MODE_IDLE;
          end else begin
            do_open = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (data_byte == CH_STAR) begin
            st_next.count     = inc_cnt;
            st_next.over      = inc_over;
            st_next.mode      = MODE_BCMT;
            st_next.prev_star = 1'b0;
          end else if (data_byte == CH_SLASH) begin
            st_next.count = inc_cnt;
            st_next.over  = inc_over;
            st_next.mode  = MODE_LCMT;
          end else if (is_delim(data_byte)) begin
            p_valid    = 1'b1;
            p_res.kind = TOK_BAD;
            do_open    = 1'b1;
          end else begin
            st_next.count      = inc_cnt;
            st_next.over       = inc_over;
            st_next.mode       = MODE_BADVAL;
            st_next.slash_held = 1'b0;
          end
        end
        MODE_STR: begin
          st_next.prev_cr = 1'b0;
          if (st.prev_cr && data_byte == CH_LF) begin
            // LF after an escaped CR is part of the string
            st_next.count = inc_cnt;
            st_next.over  = inc_over;
          end else if (is_ctrl && !st.esc && data_byte == CH_LF) begin
            // bare LF ends the string as invalid, LF opens a newline
            p_valid    = 1'b1;
            p_res.kind = TOK_BAD;
            do_open    = 1'b1;
          end else begin
            if (is_ctrl) begin
              if (!st.esc) begin
                sflags[1] = 1'b1;
              end else if (data_byte == CH_LF) begin
                sflags[0] = 1'b1;
              end else if (data_byte == CH_CR) begin
                sflags[0] = 1'b1;
                st_next.prev_cr = 1'b1;
              end else begin
                sflags[1] = 1'b1;
              end
            end
            st_next.flags = sflags;
            st_next.count = inc_cnt;
            st_next.over  = inc_over;
            if (st.esc) begin
              st_next.esc = 1'b0;
            end else if (data_byte == quote_ch) begin
              p_valid      = 1'b1;
              p_res.length = inc_cnt;
              p_res.over   = inc_over;
              if (sflags[1]) begin
                p_res.kind = TOK_BAD;
              end else if (sflags[0]) begin
                p_res.kind = TOK_MULTI;
              end else begin
                p_res.kind = TOK_STR;
              end
              st_next.mode = MODE_IDLE;
            end else if (data_byte == CH_BSLASH) begin
              st_next.esc = 1'b1;
            end
          end
        end
        MODE_LCMT: begin
          if (data_byte == CH_CR || data_byte == CH_LF) begin
            p_valid    = 1'b1;
            p_res.kind = TOK_LCMT;
            do_open    = 1'b1;
          end else begin
            st_next.count = inc_cnt;
            st_next.over  = inc_over;
          end
        end
        MODE_BCMT: begin
          st_next.count = inc_cnt;
          st_next.over  = inc_over;
          if (data_byte == CH_SLASH && st.prev_star) begin
            p_valid      = 1'b1;
            p_res.kind   = TOK_BCMT;
            p_res.length = inc_cnt;
            p_res.over   = inc_over;
            st_next.mode = MODE_IDLE;
          end else begin
            st_next.prev_star = (data_byte == CH_STAR);
          end
        end
        MODE_VAL, MODE_BADVAL: begin
          if (is_delim(data_byte)) begin
            p_valid    = 1'b1;
            p_res.kind = val_kind;
            do_open    = 1'b1;
          end else if ((data_byte == CH_SLASH || data_byte == CH_STAR) && st.slash_held) begin
            // comment opener inside a value: value ends before the slash
            p_valid    = 1'b1;
            p_res.kind = val_kind;
            if (!st.over) begin
              p_res.length = st.count - LEN_BITS'(1);
            end
            st_next.mode       = (data_byte == CH_SLASH) ? MODE_LCMT : MODE_BCMT;
            st_next.count      = LEN_BITS'(2);
            st_next.over       = 1'b0;
            st_next.prev_star  = 1'b0;
            st_next.slash_held = 1'b0;
          end else begin
            st_next.count      = inc_cnt;
            st_next.over       = inc_over;
            st_next.slash_held = (data_byte == CH_SLASH);
          end
        end
        default: begin
          do_open = 1'b1;
        end
      endcase

      // current byte opens a new token
      if (do_open) begin
        st_next.count      = LEN_BITS'(1);
        st_next.over       = 1'b0;
        st_next.esc        = 1'b0;
        st_next.flags      = 2'b00;
        st_next.prev_star  = 1'b0;
        st_next.prev_cr    = 1'b0;
        st_next.slash_held = 1'b0;
        st_next.mode       = MODE_IDLE;
        unique case (data_byte)
          CH_SPACE, CH_TAB: st_next.mode = MODE_WS;
          CH_LF: begin
            s_valid = 1'b1;
            s_res.kind = TOK_NL;
          end
          CH_CR: begin
            st_next.mode    = MODE_CR;
            st_next.prev_cr = 1'b1;
          end
          CH_LBRK: begin
            s_valid = 1'b1;
            s_res.kind = TOK_LBRK;
          end
          CH_RBRK: begin
            s_valid = 1'b1;
            s_res.kind = TOK_RBRK;
          end
          CH_LBRC: begin
            s_valid = 1'b1;
            s_res.kind = TOK_LBRC;
          end
          CH_RBRC: begin
            s_valid = 1'b1;
            s_res.kind = TOK_RBRC;
          end
          CH_COLON: begin
            s_valid = 1'b1;
            s_res.kind = TOK_COLON;
          end
          CH_COMMA: begin
            s_valid = 1'b1;
            s_res.kind = TOK_COMMA;
          end
          CH_DQUOTE: begin
            st_next.mode         = MODE_STR;
            st_next.quote_single = 1'b0;
          end
          CH_SQUOTE: begin
            st_next.mode         = MODE_STR;
            st_next.quote_single = 1'b1;
          end
          CH_SLASH: st_next.mode = MODE_SLASH;
          default:  st_next.mode = MODE_VAL;
        endcase
      end
    end
  end

  // pack results in order: pending token first
  always_comb begin
    pair.first  = p_valid ? p_res : s_res;
    pair.second = s_res;
    pair.two    = p_valid & s_valid;
    res_cnt     = {1'b0, p_valid} + {1'b0, s_valid};
  end

endmodule

### dv/tokenizer_checker.sv
`timescale 1ns / 1ps
// tokenizer_checker: predicts the token stream of json_byte_tokenizer and compares it
module tokenizer_checker
  import jbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                end_of_input,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [3:0]          token_type,
  input  logic [LEN_BITS-1:0] token_length,
  input  logic                length_saturated,
  input  logic                last,
  output int                  mismatch_count,
  output int                  tokens_pending,
  output int                  tokens_seen
);

  // one token as it should leave the block
  typedef struct packed {
    tok_t                kind;
    logic [LEN_BITS-1:0] length;
    logic                over;
    logic                last;
  } tok_expect_t;

  lex_state_t  lex;
  tok_expect_t byte_tokens[$];
  tok_expect_t expected_tokens[$];
  tok_expect_t got;

  initial begin
    mismatch_count = 0;
    tokens_pending = 0;
    tokens_seen = 0;
    lex = LEX_RESET;
  end

  // a byte closes at most two tokens
  function automatic void note_token(tok_t kind, logic [LEN_BITS-1:0] len, logic over);
    tok_expect_t t;
    if (byte_tokens.size() >= 2) return;
    t.kind = kind;
    t.length = len;
    t.over = over;
    t.last = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  // length grows until it sticks at the maximum
  function automatic void count_byte();
    if (lex.count == LEN_MAX) lex.over = 1'b1;
    else lex.count = lex.count + LEN_BITS'(1);
  endfunction

  function automatic void close_open(tok_t kind);
    note_token(kind, lex.count, lex.over);
    lex.mode = MODE_IDLE;
  endfunction

  function automatic logic is_delim(logic [7:0] b);
    case (b)
      CH_TAB, CH_LF, CH_CR, CH_SPACE, CH_DQUOTE, CH_COMMA, CH_COLON,
      CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // invalid beats multiline
  function automatic tok_t string_kind();
    if (lex.flags[1]) return TOK_BAD;
    if (lex.flags[0]) return TOK_MULTI;
    return TOK_STR;
  endfunction

  // first byte of a new token; single-byte tokens close at once
  function automatic void start_token(logic [7:0] b);
    lex.count = LEN_BITS'(1);
    lex.over = 1'b0;
    lex.esc = 1'b0;
    lex.flags = 2'b00;
    lex.prev_star = 1'b0;
    lex.prev_cr = 1'b0;
    lex.slash_held = 1'b0;
    lex.mode = MODE_IDLE;
    case (b)
      CH_SPACE, CH_TAB: lex.mode = MODE_WS;
      CH_LF: note_token(TOK_NL, LEN_BITS'(1), 1'b0);
      CH_CR: begin
        lex.mode = MODE_CR;
        lex.prev_cr = 1'b1;
      end
      CH_LBRK: note_token(TOK_LBRK, LEN_BITS'(1), 1'b0);
      CH_RBRK: note_token(TOK_RBRK, LEN_BITS'(1), 1'b0);
      CH_LBRC: note_token(TOK_LBRC, LEN_BITS'(1), 1'b0);
      CH_RBRC: note_token(TOK_RBRC, LEN_BITS'(1), 1'b0);
      CH_COLON: note_token(TOK_COLON, LEN_BITS'(1), 1'b0);
      CH_COMMA: note_token(TOK_COMMA, LEN_BITS'(1), 1'b0);
      CH_DQUOTE: begin
        lex.mode = MODE_STR;
        lex.quote_single = 1'b0;
      end
      CH_SQUOTE: begin
        lex.mode = MODE_STR;
        lex.quote_single = 1'b1;
      end
      CH_SLASH: lex.mode = MODE_SLASH;
      default: lex.mode = MODE_VAL;
    endcase
  endfunction

  // byte inside a quoted string
  function automatic void string_byte(logic [7:0] b);
    logic [7:0] q;
    q = lex.quote_single ? CH_SQUOTE : CH_DQUOTE;
    // LF right after an escaped CR belongs to the string
    if (lex.prev_cr) begin
      lex.prev_cr = 1'b0;
      if (b == CH_LF) begin
        count_byte();
        return;
      end
    end
    if (b >= 8'h01 && b < CH_SPACE) begin
      if (!lex.esc) begin
        // bare LF cuts the string off and becomes a newline
        if (b == CH_LF) begin
          close_open(TOK_BAD);
          start_token(b);
          return;
        end
        lex.flags[1] = 1'b1;
      end else if (b == CH_LF) begin
        lex.flags[0] = 1'b1;
      end else if (b == CH_CR) begin
        lex.flags[0] = 1'b1;
        lex.prev_cr = 1'b1;
      end else begin
        lex.flags[1] = 1'b1;
      end
    end
    count_byte();
    if (lex.esc) lex.esc = 1'b0;
    else if (b == q) close_open(string_kind());
    else if (b == CH_BSLASH) lex.esc = 1'b1;
  endfunction

  // byte inside a bare value
  function automatic void value_byte(logic [7:0] b);
    tok_t kind;
    kind = (lex.mode == MODE_BADVAL) ? TOK_BAD : TOK_VALUE;
    if (is_delim(b)) begin
      close_open(kind);
      start_token(b);
    end else if ((b == CH_SLASH || b == CH_STAR) && lex.slash_held) begin
      // comment opener splits off; the held slash leaves the value
      if (lex.over) note_token(kind, lex.count, 1'b1);
      else note_token(kind, lex.count - LEN_BITS'(1), 1'b0);
      lex.mode = (b == CH_SLASH) ? MODE_LCMT : MODE_BCMT;
      lex.count = LEN_BITS'(2);
      lex.over = 1'b0;
      lex.prev_star = 1'b0;
      lex.slash_held = 1'b0;
    end else begin
      count_byte();
      lex.slash_held = (b == CH_SLASH);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] b);
    case (lex.mode)
      MODE_WS: begin
        if (b == CH_SPACE || b == CH_TAB) count_byte();
        else begin
          close_open(TOK_WS);
          start_token(b);
        end
      end
      MODE_CR: begin
        lex.prev_cr = 1'b0;
        if (b == CH_LF) begin
          count_byte();
          close_open(TOK_NL);
        end else begin
          close_open(TOK_NL);
          start_token(b);
        end
      end
      MODE_SLASH: begin
        if (b == CH_STAR) begin
          count_byte();
          lex.mode = MODE_BCMT;
          lex.prev_star = 1'b0;
        end else if (b == CH_SLASH) begin
          count_byte();
          lex.mode = MODE_LCMT;
        end else if (is_delim(b)) begin
          close_open(TOK_BAD);
          start_token(b);
        end else begin
          count_byte();
          lex.mode = MODE_BADVAL;
          lex.slash_held = 1'b0;
        end
      end
      MODE_STR: string_byte(b);
      MODE_LCMT: begin
        if (b == CH_CR || b == CH_LF) begin
          close_open(TOK_LCMT);
          start_token(b);
        end else begin
          count_byte();
        end
      end
      MODE_BCMT: begin
        count_byte();
        if (b == CH_SLASH && lex.prev_star) close_open(TOK_BCMT);
        else lex.prev_star = (b == CH_STAR);
      end
      MODE_VAL, MODE_BADVAL: value_byte(b);
      default: start_token(b);
    endcase
  endfunction

  // end of text: flush whatever is open, then end-of-file
  function automatic void lex_flush();
    tok_t kind;
    case (lex.mode)
      MODE_WS: kind = TOK_WS;
      MODE_CR: kind = TOK_NL;
      MODE_LCMT: kind = TOK_LCMT;
      MODE_VAL: kind = TOK_VALUE;
      default: kind = TOK_BAD;
    endcase
    if (lex.mode != MODE_IDLE) note_token(kind, lex.count, lex.over);
    note_token(TOK_EOF, '0, 1'b0);
    lex = LEX_RESET;
  endfunction

  function automatic void check_field(string what, int want, int seen);
    if (want != seen) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, seen);
      mismatch_count++;
    end
  endfunction

  // predict on each accepted request, compare each accepted token
  always @(posedge clk) begin
    if (rst) begin
      lex = LEX_RESET;
      expected_tokens.delete();
    end else begin
      if (in_valid && !in_stall) begin
        byte_tokens.delete();
        if (end_of_input) lex_flush();
        else lex_byte(data_byte);
        if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
        foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
      end
      if (out_valid && !out_stall) begin
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          $display("%0t ns: token with nothing expected, type %0d length %0d",
                   $time, token_type, token_length);
          mismatch_count++;
        end else begin
          got = expected_tokens.pop_front();
          check_field("token_type", got.kind, token_type);
          check_field("token_length", got.length, token_length);
          check_field("length_saturated", got.over, length_saturated);
          check_field("last", got.last, last);
        end
      end
    end
    tokens_pending = expected_tokens.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench: drives json text into json_byte_tokenizer and gives the verdict
module testbench;
  import jbt_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic [7:0]          data_byte = 8'h00;
  logic                end_of_input = 1'b0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [3:0]          token_type;
  logic [LEN_BITS-1:0] token_length;
  logic                length_saturated;
  logic                last;

  int   mismatch_count;
  int   tokens_pending;
  int   tokens_seen;
  int   bytes_sent = 0;
  int   eofs_sent = 0;
  int   stall_left = 0;
  int   stall_roll;
  int   random_start;

  always #2 clk = ~clk;

  json_byte_tokenizer u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .end_of_input     (end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .token_type       (token_type),
    .token_length     (token_length),
    .length_saturated (length_saturated),
    .last             (last)
  );

  tokenizer_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .end_of_input     (end_of_input),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .token_type       (token_type),
    .token_length     (token_length),
    .length_saturated (length_saturated),
    .last             (last),
    .mismatch_count   (mismatch_count),
    .tokens_pending   (tokens_pending),
    .tokens_seen      (tokens_seen)
  );

  // output back-pressure: mostly short bursts, now and then a long one
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 50) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(0, 6);
      end else if (stall_roll < 90) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // one request: optional idle gap, then hold until taken
  task automatic send_item(input logic [7:0] b, input logic eoi);
    int n;
    int r;
    n = 0;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n > 0) begin
      in_valid <= 1'b0;
      data_byte <= 8'($urandom_range(0, 255));
      end_of_input <= 1'($urandom_range(0, 1));
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (eoi) eofs_sent++;
    else bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(b, 1'b0);
  endtask

  // data byte is random and must be ignored
  task automatic send_eof();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // one mostly well-formed token with random content, or some noise
  task automatic send_random_token();
    int r;
    int c;
    int n;
    int i;
    logic [7:0] q;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) send_byte(pick(" \t"));
    end else if (r < 20) begin
      c = $urandom_range(0, 2);
      if (c != 0) send_byte(CH_CR);
      if (c != 2) send_byte(CH_LF);
    end else if (r < 38) begin
      send_byte(pick("[]{}:,"));
    end else if (r < 58) begin
      // quoted string with escapes, stray control bytes and odd endings
      q = ($urandom_range(0, 3) == 0) ? CH_SQUOTE : CH_DQUOTE;
      send_byte(q);
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        c = $urandom_range(0, 99);
        if (c < 60) begin
          send_byte(pick("abcxyz019 _-+.,:[]{}/*#"));
        end else if (c < 78) begin
          send_byte(CH_BSLASH);
          c = $urandom_range(0, 9);
          if (c < 5) send_byte(pick("\"'\\/bnrtu"));
          else if (c < 7) send_byte(CH_LF);
          else if (c < 9) begin
            send_byte(CH_CR);
            if ($urandom_range(0, 1) == 1) send_byte(CH_LF);
          end else send_byte(8'($urandom_range(1, 31)));
        end else if (c < 86) begin
          send_byte((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
        end else if (c < 93) begin
          send_byte(8'($urandom_range(1, 31)));
        end else begin
          send_byte(($urandom_range(0, 1) == 1) ? 8'h00 : 8'($urandom_range(128, 255)));
        end
      end
      c = $urandom_range(0, 19);
      if (c < 18) send_byte(q);
      else if (c == 18) send_byte(CH_LF);
    end else if (r < 76) begin
      // bare value, may hold a comment opener
      send_byte(pick("-0123456789tfnabxyzE.'"));
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) send_byte(pick("0123456789.eE+-abxyz_'*/"));
    end else if (r < 82) begin
      send_text("//");
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++) send_byte(pick("ab */\t\"'"));
    end else if (r < 88) begin
      send_text("/*");
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) send_byte(pick("ab *\n/\015"));
      send_text("*/");
    end else if (r < 92) begin
      send_byte(CH_SLASH);
      send_byte(pick(" ,]x9:"));
    end else if (r < 99) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_eof();
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // whitespace, newlines in all forms, punctuation
    send_text(" \t \015\n\015[]{}:,\n");
    // escaped quote, single-quoted string holding a double quote
    send_text("\"ab\\\"c\" 'it\"s'");
    // escaped LF, escaped CR followed by LF: multiline
    send_text("\"x\\\ny\\\015\nz\"");
    // control bytes make the string invalid even with an escaped LF
    send_text("\"a");
    send_byte(8'h01);
    send_byte(CH_BSLASH);
    send_byte(CH_TAB);
    send_text("\\\n\"");
    // bare LF cuts a string off
    send_text("\"ab\n");
    // lone slash before a letter, then before a delimiter
    send_text("/x/ /,");
    // comments opened inside values, quote inside a value
    send_text("ab//c\015de/*q*/f it's ");
    // star-slash overlapping the opener does not close
    send_text("/*/ */");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CH_SPACE);
    // flush of every kind of open token at end of text
    send_text("\"open");
    send_eof();
    send_text("/*x");
    send_eof();
    send_byte(CH_CR);
    send_eof();
    send_byte(CH_SLASH);
    send_eof();
    send_text("/q");
    send_eof();
    send_text("// c");
    send_eof();
    send_text("v");
    send_eof();
    send_eof();
    send_text("  ");
    send_eof();

    random_start = bytes_sent + eofs_sent;
    while (bytes_sent + eofs_sent - random_start < 1100) send_random_token();
    send_eof();
    in_valid <= 1'b0;

    // drain
    @(posedge clk);
    while (tokens_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d text bytes and %0d end-of-text marks; %0d tokens compared",
             bytes_sent, eofs_sent, tokens_seen);
    $display("including comment splits inside values and unclosed-token flushes");
    if (tokens_pending != 0) $display("%0d tokens never arrived", tokens_pending);
    if (mismatch_count == 0 && tokens_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop
  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule

### json_byte_tokenizer.f
rtl/jbt_pkg.sv
rtl/jbt_lexer.sv
rtl/json_byte_tokenizer.sv
dv/tokenizer_checker.sv
dv/testbench.sv
